// ===== src/bmp_row_palette_unpacker_unit_defines.svh =====
// Assertion helpers for the bitmap row unpacker checks.
`ifndef BMP_ROW_PALETTE_UNPACKER_UNIT_DEFINES_SVH
`define BMP_ROW_PALETTE_UNPACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define BPU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpu check failed");

// next-cycle implication
`define BPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpu check failed");

`endif

// ===== src/bpu_pkg.sv =====
`default_nettype none

package bpu_pkg;

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;
    localparam int IMG_WIDTH_MAX = (1 << CFG_DATA_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b1;

    localparam logic REQ_ROW_BYTE  = 1'b0;
    localparam logic REQ_PAL_WRITE = 1'b1;

    typedef enum logic [1:0] {
        DEPTH_1B  = 2'd0,
        DEPTH_4B  = 2'd1,
        DEPTH_8B  = 2'd2,
        DEPTH_24B = 2'd3
    } depth_t;

    // 24-bit byte gathering: blue, green, red
    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic [7:0] pal_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       last;
    } pixel_t;

    // what one row byte turns into
    typedef struct packed {
        logic [3:0]  count;
        logic        row_end_last;
        logic        direct;
        logic [23:0] rgb;
    } byte_plan_t;

    // one pixel entering the lookup stage
    typedef struct packed {
        logic        valid;
        logic [7:0]  idx;
        logic        last;
        logic        row_end;
        logic        direct;
        logic [23:0] rgb;
    } pix_issue_t;

    function automatic logic [7:0] index_of(depth_t d, logic [7:0] b);
        logic [7:0] r;
        case (d)
            DEPTH_1B: r = {7'b0, b[7]};
            DEPTH_4B: r = {4'b0, b[7:4]};
            default:  r = b;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] shift_out(depth_t d, logic [7:0] b);
        logic [7:0] r;
        case (d)
            DEPTH_1B: r = {b[6:0], 1'b0};
            DEPTH_4B: r = {b[3:0], 4'b0};
            default:  r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bpu_stream_if.sv =====
`default_nettype none

interface bpu_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/bpu_row_ctrl.sv =====
`default_nettype none

module bpu_row_ctrl #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            byte_en,
    input  logic [7:0]                      data_byte,
    output bpu_pkg::depth_t                 depth,
    output bpu_pkg::byte_plan_t             plan
);
    import bpu_pkg::*;

    localparam int EFF_MAX = (MAX_WIDTH < IMG_WIDTH_MAX) ? MAX_WIDTH : IMG_WIDTH_MAX;
    localparam int CW  = $clog2(EFF_MAX + 1);
    localparam int RBW = CW + 2;
    localparam int PW  = CW + 6;

    depth_t                depth_reg, depth_next;
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [RBW-1:0]        rbc_reg, rbc_next;
    phase_t                phase_reg, phase_next;
    logic [15:0]           held_reg, held_next;

    logic [CW-1:0] eff_w;
    logic [CW-1:0] rem;
    logic [CW-1:0] col_new;
    logic [PW-1:0] wx;
    logic [PW-1:0] prod;
    logic [PW-1:0] row_len;
    logic [PW-1:0] rbc_inc;
    logic          active;
    logic          row_done;
    logic [3:0]    pix_count;
    logic          pix_direct;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = CW'(1);
        else if (32'(width_reg) > 32'(EFF_MAX))
            eff_w = CW'(EFF_MAX);
        else
            eff_w = CW'(width_reg);
    end

    assign wx = PW'(eff_w);

    always_comb
    begin
        case (depth_reg)
            DEPTH_1B: prod = wx;
            DEPTH_4B: prod = wx << 2;
            DEPTH_8B: prod = wx << 3;
            default:  prod = (wx << 4) + (wx << 3);
        endcase
    end

    // round up to whole 32-bit words, in bytes
    assign row_len  = ((prod + PW'(31)) >> 5) << 2;
    assign rbc_inc  = PW'(rbc_reg) + PW'(1);
    assign row_done = rbc_inc >= row_len;
    assign active   = col_reg < eff_w;
    assign rem      = eff_w - col_reg;

    always_comb
    begin
        pix_count  = 4'd0;
        pix_direct = 1'b0;
        if (active)
        begin
            case (depth_reg)
                DEPTH_1B: pix_count = (rem >= CW'(8)) ? 4'd8 : 4'(rem);
                DEPTH_4B: pix_count = (rem >= CW'(2)) ? 4'd2 : 4'(rem);
                DEPTH_8B: pix_count = 4'd1;
                default:
                begin
                    pix_count  = (phase_reg == PH_RED) ? 4'd1 : 4'd0;
                    pix_direct = 1'b1;
                end
            endcase
        end
    end

    assign col_new = col_reg + CW'(pix_count);

    always_comb
    begin
        plan              = '0;
        plan.count        = pix_count;
        plan.direct       = pix_direct;
        plan.rgb          = {data_byte, held_reg[7:0], held_reg[15:8]};
        plan.row_end_last = (col_new == eff_w);
    end

    always_comb
    begin
        depth_next = depth_reg;
        width_next = width_reg;
        col_next   = col_reg;
        rbc_next   = rbc_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_PIXEL_DEPTH: depth_next = depth_t'(cfg_data[1:0]);
                CFG_IMAGE_WIDTH: width_next = cfg_data;
                default: ;
            endcase
            col_next   = '0;
            rbc_next   = '0;
            phase_next = PH_BLUE;
        end
        else if (byte_en)
        begin
            if (active && depth_reg == DEPTH_24B)
            begin
                case (phase_reg)
                    PH_BLUE:
                    begin
                        held_next[15:8] = data_byte;
                        phase_next      = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        held_next[7:0] = data_byte;
                        phase_next     = PH_RED;
                    end
                    default: phase_next = PH_BLUE;
                endcase
            end
            col_next = col_new;
            rbc_next = rbc_inc[RBW-1:0];
            if (row_done)
            begin
                col_next   = '0;
                rbc_next   = '0;
                phase_next = PH_BLUE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_8B;
            width_reg <= CFG_DATA_W'(1);
            col_reg   <= '0;
            rbc_reg   <= '0;
            phase_reg <= PH_BLUE;
            held_reg  <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            width_reg <= width_next;
            col_reg   <= col_next;
            rbc_reg   <= rbc_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    assign depth = depth_reg;

endmodule

`default_nettype wire

// ===== src/bpu_pixel_seq.sv =====
`default_nettype none

module bpu_pixel_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 advance,
    input  bpu_pkg::depth_t      depth,
    input  logic [7:0]           data_byte,
    input  bpu_pkg::byte_plan_t  plan,
    output bpu_pkg::pix_issue_t  issue,
    output logic                 busy
);
    import bpu_pkg::*;

    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] byte_reg, byte_next;
    depth_t     depth_reg, depth_next;
    logic       rowend_reg, rowend_next;

    assign busy = (cnt_reg != 4'd0);

    // first pixel of a fresh byte goes out in the accept cycle
    always_comb
    begin
        issue       = '0;
        cnt_next    = cnt_reg;
        byte_next   = byte_reg;
        depth_next  = depth_reg;
        rowend_next = rowend_reg;
        if (busy)
        begin
            issue.valid   = 1'b1;
            issue.idx     = index_of(depth_reg, byte_reg);
            issue.last    = (cnt_reg == 4'd1);
            issue.row_end = (cnt_reg == 4'd1) && rowend_reg;
            if (advance)
            begin
                cnt_next  = cnt_reg - 4'd1;
                byte_next = shift_out(depth_reg, byte_reg);
            end
        end
        else if (start && plan.count != 4'd0)
        begin
            issue.valid   = 1'b1;
            issue.idx     = index_of(depth, data_byte);
            issue.last    = (plan.count == 4'd1);
            issue.row_end = (plan.count == 4'd1) && plan.row_end_last;
            issue.direct  = plan.direct;
            issue.rgb     = plan.rgb;
            cnt_next      = plan.count - 4'd1;
            byte_next     = shift_out(depth, data_byte);
            depth_next    = depth;
            rowend_next   = plan.row_end_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        depth_reg  <= depth_next;
        rowend_reg <= rowend_next;
    end

endmodule

`default_nettype wire

// ===== src/bpu_palette.sv =====
`default_nettype none

module bpu_palette #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_idx,
    input  logic [23:0] wr_rgb,
    input  logic        rd_en,
    input  logic [7:0]  rd_idx,
    output logic [23:0] rd_rgb
);
    localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

    logic [23:0]             pal_mem_reg [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] valid_reg;
    logic [23:0]             rd_data_reg;
    logic                    hit_reg;

    logic          wr_ok;
    logic          rd_ok;
    logic [AW-1:0] wa;
    logic [AW-1:0] ra;

    assign wr_ok = {1'b0, wr_idx} < 9'(PALETTE_SIZE);
    assign rd_ok = {1'b0, rd_idx} < 9'(PALETTE_SIZE);
    assign wa    = wr_idx[AW-1:0];
    assign ra    = rd_idx[AW-1:0];

    // unloaded or out-of-range entries read black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_ok)
                valid_reg[wa] <= 1'b1;
            if (rd_en)
                hit_reg <= rd_ok && valid_reg[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
            pal_mem_reg[wa] <= wr_rgb;
        if (rd_en)
            rd_data_reg <= pal_mem_reg[ra];
    end

    assign rd_rgb = hit_reg ? rd_data_reg : 24'd0;

endmodule

`default_nettype wire

// ===== src/bmp_row_palette_unpacker_unit.sv =====
`default_nettype none
// channel   dir  beat       fields
// item      in   in_item_t  req_type data_byte pal_index pal_red pal_green pal_blue
// pixel     out  pixel_t    red green blue row_end last
// cfg       in   write      cfg_we cfg_idx cfg_data
//
// Palette writes, 8-bit and 24-bit bytes: one item per cycle unless stalled.
// 4-bit bytes give up to 2 pixels, 1-bit bytes up to 8: one pixel per cycle
// unless stalled, through the single palette read port, sequenced from the
// accepted byte; the next item waits for the last pixel. Pixels pass the lookup
// stage and output register. Reset clears palette valid flags at once; no clearing
// pass. pixel.ready low holds out_reg and a full lookup stage; item.ready drops.

module bmp_row_palette_unpacker_unit #(
    parameter int MAX_WIDTH    = 4096,
    parameter int PALETTE_SIZE = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bpu_stream_if.sink                      item,
    bpu_stream_if.source                    pixel,
    input  logic                            cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpu_pkg::*;

    depth_t     depth;
    byte_plan_t plan;
    pix_issue_t issue;
    logic       busy;

    logic       out_load;
    logic       s1_adv;
    logic       in_ready;
    logic       accept;
    logic       byte_en;
    logic       pal_we;
    logic       rd_en;
    logic [23:0] rd_rgb;
    logic [23:0] s1_rgb;

    logic       s1_v_reg;
    pix_issue_t s1_reg;
    logic       out_v_reg;
    pixel_t     out_reg;

    assign out_load = !out_v_reg || pixel.ready;
    assign s1_adv   = !s1_v_reg || out_load;
    assign in_ready = !busy && s1_adv;
    assign accept   = item.valid && in_ready;
    assign byte_en  = accept && (item.data.req_type == REQ_ROW_BYTE);
    assign pal_we   = accept && (item.data.req_type == REQ_PAL_WRITE);
    assign rd_en    = s1_adv && issue.valid && !issue.direct;

    assign item.ready = in_ready;

    bpu_row_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .byte_en   (byte_en),
        .data_byte (item.data.data_byte),
        .depth     (depth),
        .plan      (plan)
    );

    bpu_pixel_seq u_pixel_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (byte_en),
        .advance   (s1_adv),
        .depth     (depth),
        .data_byte (item.data.data_byte),
        .plan      (plan),
        .issue     (issue),
        .busy      (busy)
    );

    bpu_palette #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_palette (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (pal_we),
        .wr_idx (item.data.pal_index),
        .wr_rgb ({item.data.pal_red, item.data.pal_green, item.data.pal_blue}),
        .rd_en  (rd_en),
        .rd_idx (issue.idx),
        .rd_rgb (rd_rgb)
    );

    assign s1_rgb = s1_reg.direct ? s1_reg.rgb : rd_rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_v_reg <= issue.valid;
            if (out_load)
                out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            s1_reg <= issue;
        if (out_load && s1_v_reg)
        begin
            out_reg.red     <= s1_rgb[23:16];
            out_reg.green   <= s1_rgb[15:8];
            out_reg.blue    <= s1_rgb[7:0];
            out_reg.row_end <= s1_reg.row_end;
            out_reg.last    <= s1_reg.last;
        end
    end

    assign pixel.valid = out_v_reg;
    assign pixel.data  = out_reg;

endmodule

`default_nettype wire

// ===== src/bpu_checker.sv =====
`default_nettype none
`include "bmp_row_palette_unpacker_unit_defines.svh"

module bpu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_ready,
    input bpu_pkg::pixel_t  pixel_data
);
    import bpu_pkg::*;

    // row end only falls on the final pixel of a byte
    `BPU_ASSERT_IMP(a_row_end_is_last, pixel_valid && pixel_data.row_end, pixel_data.last)

    // pixels of one byte follow without a gap
    `BPU_ASSERT_NEXT(a_byte_burst, pixel_valid && !pixel_data.last, pixel_valid)

    `BPU_ASSERT_NEXT(a_hold_valid, pixel_valid && !pixel_ready, pixel_valid)

    `BPU_ASSERT_NEXT(a_hold_data, pixel_valid && !pixel_ready, $stable(pixel_data))

endmodule

bind bmp_row_palette_unpacker_unit bpu_checker u_bpu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .pixel_data  (pixel.data)
);

`default_nettype wire
